// ----- hdl/nau_pkg.sv -----
`timescale 1ns / 1ps

package nau_pkg;

    // activation function select
    typedef enum logic [2:0] {
        MODE_NOOP  = 3'd0,
        MODE_RELU  = 3'd1,
        MODE_CLIP  = 3'd2,
        MODE_LEAKY = 3'd3,
        MODE_TANH  = 3'd4,
        MODE_SIG   = 3'd5,
        MODE_ELU   = 3'd6,
        MODE_RSVD  = 3'd7
    } t_mode;

    // configuration register index
    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_CLIP  = 2'd1,
        REG_ALPHA = 2'd2,
        REG_NONE  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ROM_TANH = 2'd0,
        ROM_SIG  = 2'd1,
        ROM_EXP  = 2'd2
    } t_rom_kind;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CLIP_W      = 15;
    localparam int ALPHA_W     = 16;
    localparam int LUT_W       = 24;
    localparam int FRAC_W      = 12;
    localparam int CLAMP_LO    = -2048;
    localparam int CLAMP_HI    = 2047;
    localparam int CLIP_RESET  = 1536;
    localparam int Q8_ONE      = 256;

    localparam longint unsigned Q30_ONE  = 64'd1073741824;
    localparam longint unsigned Q30_MASK = 64'd1073741823;

    // per-stage advance enables shared with the datapath units
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
        logic en5;
    } t_pipe_ctl;

    // unsigned quotient by shift and subtract, elaboration only
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
        longint unsigned hi;
        longint unsigned lo;
        hi = a >> 30;
        lo = a & Q30_MASK;
        return hi * b + ((lo * b + (64'd1 << 29)) >> 30);
    endfunction

    function automatic longint unsigned series_exp(longint unsigned f);
        longint unsigned sum;
        longint unsigned term;
        sum  = Q30_ONE;
        term = Q30_ONE;
        for (int i = 1; i <= 24; i++) begin
            term = udiv(mul_q30(term, f), unsigned'(longint'(i)));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // e^(p/d) in Q30, elaboration only
    function automatic longint unsigned exp_ratio(longint p, longint d);
        longint unsigned e1;
        longint unsigned einv;
        longint n;
        longint rem;
        longint unsigned v;
        e1   = series_exp(Q30_ONE);
        einv = udiv((64'd1 << 60) + e1 / 2, e1);
        if (p >= 0) begin
            n = longint'(udiv(unsigned'(p), unsigned'(d)));
        end else begin
            n = -longint'(udiv(unsigned'(-p + d - 1), unsigned'(d)));
        end
        rem = p - n * d;
        v = series_exp(udiv((unsigned'(rem) << 30) + unsigned'(d) / 2, unsigned'(d)));
        while (n > 0) begin
            v = mul_q30(v, e1);
            n = n - 1;
        end
        while (n < 0) begin
            v = mul_q30(v, einv);
            n = n + 1;
        end
        return v;
    endfunction

    // breakpoint k of a table with s segments
    function automatic logic signed [LUT_W-1:0] rom_value(t_rom_kind kind, int k, int s);
        longint p;
        longint ap;
        longint unsigned z;
        longint unsigned den;
        longint unsigned y;
        longint res;
        p  = 16 * longint'(k) - 8 * longint'(s);
        ap = (p < 0) ? -p : p;
        res = 0;
        unique case (kind)
            ROM_EXP: begin
                res = longint'((exp_ratio(p, s) + (64'd1 << 21)) >> 22);
            end
            ROM_SIG: begin
                z   = exp_ratio(-ap, s);
                den = Q30_ONE + z;
                if (p >= 0) begin
                    y = udiv((64'd1 << 38) + den / 2, den);
                end else begin
                    y = udiv((z << 8) + den / 2, den);
                end
                res = longint'(y);
            end
            ROM_TANH: begin
                z   = exp_ratio(-2 * ap, s);
                den = Q30_ONE + z;
                y   = udiv(((Q30_ONE - z) << 8) + den / 2, den);
                res = (p < 0) ? -longint'(y) : longint'(y);
            end
            default: res = 0;
        endcase
        return res[LUT_W-1:0];
    endfunction

endpackage

// ----- hdl/nau_stream_if.sv -----
`timescale 1ns / 1ps

interface nau_in_if #(parameter int DATA_WIDTH = 16);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] sample;
    logic                  last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface nau_out_if #(parameter int DATA_WIDTH = 16);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] result;
    logic                  result_last;

    modport source (output valid, output result, output result_last, input ready);
    modport sink   (input valid, input result, input result_last, output ready);
endinterface

interface nau_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/neural_activation_unit.sv -----
`timescale 1ns / 1ps
// channel   modport  payload                    meaning
// i_in      sink     sample, last               one sample transaction in
// o_out     source   result, result_last        one activated transaction out
// i_cfg     sink     index, data                register write (always ready)
//
// five register stages: clamp/segment, table read, interpolate, multiply, round
// one transaction per cycle while o_out is not stalled; the table
// read and the shared alpha multiplier each take a stage of their own
// synchronous active-low reset clears valid bits and the three registers
// each stage holds while the one after it is full and stalled; bubbles collapse
module neural_activation_unit #(
    parameter int DATA_WIDTH     = 16,
    parameter int TABLE_SEGMENTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nau_in_if.sink        i_in,
    nau_out_if.source     o_out,
    nau_cfg_if.sink       i_cfg
);
    import nau_pkg::*;

    localparam int IW = $clog2(TABLE_SEGMENTS + 1);
    localparam int XW = ((DATA_WIDTH > FRAC_W) ? DATA_WIDTH : FRAC_W) + 1;
    localparam int PW = FRAC_W + IW;

    // configuration registers
    t_mode                    r_mode;
    logic [CLIP_W-1:0]        r_clip;
    logic signed [ALPHA_W-1:0] r_alpha;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NOOP;
            r_clip  <= CLIP_W'(CLIP_RESET);
            r_alpha <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_reg'(i_cfg.index))
                REG_MODE:  r_mode  <= t_mode'(i_cfg.data[2:0]);
                REG_CLIP:  r_clip  <= i_cfg.data[CLIP_W-1:0];
                REG_ALPHA: r_alpha <= i_cfg.data;
                default: ;  // writes past the list are dropped
            endcase
        end
    end

    // per-stage valid bits and the backward enable chain
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic en1;
    t_pipe_ctl ctl;

    assign ctl.en5 = !r5_v || o_out.ready;
    assign ctl.en4 = !r4_v || ctl.en5;
    assign ctl.en3 = !r3_v || ctl.en4;
    assign ctl.en2 = !r2_v || ctl.en3;
    assign en1     = !r1_v || ctl.en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en1)     r1_v <= i_in.valid;
            if (ctl.en2) r2_v <= r1_v;
            if (ctl.en3) r3_v <= r2_v;
            if (ctl.en4) r4_v <= r3_v;
            if (ctl.en5) r5_v <= r4_v;
        end
    end

    // stage 1: clamp to [-8, 8) and split into segment index and fraction
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] xc;
    logic [FRAC_W-1:0]    u;
    logic [PW-1:0]        pos;
    logic [IW-1:0]        n1_idx;
    logic [FRAC_W-1:0]    n1_frac;

    always_comb begin
        xs = XW'($signed(i_in.sample));
        if (xs < XW'(CLAMP_LO)) begin
            xc = XW'(CLAMP_LO);
        end else if (xs > XW'(CLAMP_HI)) begin
            xc = XW'(CLAMP_HI);
        end else begin
            xc = xs;
        end
        u       = FRAC_W'(xc - XW'(CLAMP_LO));
        pos     = PW'(u) * PW'(TABLE_SEGMENTS);
        n1_idx  = pos[PW-1:FRAC_W];
        n1_frac = pos[FRAC_W-1:0];
    end

    logic signed [DATA_WIDTH-1:0] r1_x, r2_x, r3_x;
    logic r1_last, r2_last, r3_last, r4_last, r5_last;
    logic [IW-1:0]     r1_idx;
    logic [FRAC_W-1:0] r1_frac;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x    <= i_in.sample;
            r1_last <= i_in.last;
            r1_idx  <= n1_idx;
            r1_frac <= n1_frac;
        end
        if (ctl.en2) begin
            r2_x    <= r1_x;
            r2_last <= r1_last;
        end
        if (ctl.en3) begin
            r3_x    <= r2_x;
            r3_last <= r2_last;
        end
        if (ctl.en4) r4_last <= r3_last;
        if (ctl.en5) r5_last <= r4_last;
    end

    // table selection follows the mode; elu reads the exp table
    t_rom_kind kind;
    always_comb begin
        unique case (r_mode)
            MODE_TANH: kind = ROM_TANH;
            MODE_SIG:  kind = ROM_SIG;
            default:   kind = ROM_EXP;
        endcase
    end

    logic signed [LUT_W-1:0] lut;

    // stages 2 and 3
    nau_lut #(
        .TABLE_SEGMENTS (TABLE_SEGMENTS)
    ) u_lut (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_kind (kind),
        .i_idx  (r1_idx),
        .i_frac (r1_frac),
        .o_lut  (lut)
    );

    // stages 4 and 5
    nau_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_mode   (r_mode),
        .i_clip   (r_clip),
        .i_alpha  (r_alpha),
        .i_x      (r3_x),
        .i_lut    (lut),
        .o_result (o_out.result)
    );

    assign o_out.valid       = r5_v;
    assign o_out.result_last = r5_last;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r1_v)
        else $error("accepted transaction did not enter stage 1");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.result)
            && $stable(o_out.result_last)))
        else $error("stalled result changed");

    a_mid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !ctl.en3) |=> (r3_v && $stable(r3_x) && $stable(r3_last)))
        else $error("stage 3 lost data during a stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule

// ----- hdl/nau_lut.sv -----
`timescale 1ns / 1ps

module nau_lut #(
    parameter int TABLE_SEGMENTS = 64
) (
    input  logic                               i_clk,
    input  nau_pkg::t_pipe_ctl                 i_ctl,
    input  nau_pkg::t_rom_kind                 i_kind,
    input  logic [$clog2(TABLE_SEGMENTS+1)-1:0] i_idx,
    input  logic [nau_pkg::FRAC_W-1:0]         i_frac,
    output logic signed [nau_pkg::LUT_W-1:0]   o_lut
);
    import nau_pkg::*;

    localparam int IW = $clog2(TABLE_SEGMENTS + 1);

    logic signed [LUT_W-1:0] tab_tanh [0:TABLE_SEGMENTS];
    logic signed [LUT_W-1:0] tab_sig  [0:TABLE_SEGMENTS];
    logic signed [LUT_W-1:0] tab_exp  [0:TABLE_SEGMENTS];

    for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_rom
        localparam logic signed [LUT_W-1:0] V_T = rom_value(ROM_TANH, k, TABLE_SEGMENTS);
        localparam logic signed [LUT_W-1:0] V_S = rom_value(ROM_SIG, k, TABLE_SEGMENTS);
        localparam logic signed [LUT_W-1:0] V_E = rom_value(ROM_EXP, k, TABLE_SEGMENTS);
        assign tab_tanh[k] = V_T;
        assign tab_sig[k]  = V_S;
        assign tab_exp[k]  = V_E;
    end

    logic [IW-1:0]           idx1;
    logic signed [LUT_W-1:0] y0;
    logic signed [LUT_W-1:0] y1;
    logic signed [LUT_W-1:0] n_y0;
    logic signed [LUT_W:0]   n_d;
    logic signed [LUT_W-1:0] r_y0;
    logic signed [LUT_W:0]   r_d;
    logic [FRAC_W-1:0]       r_frac;
    logic signed [LUT_W+FRAC_W+2:0] prod;
    logic signed [LUT_W-1:0] n_lut;
    logic signed [LUT_W-1:0] r_lut;

    assign idx1 = i_idx + IW'(1);

    always_comb begin
        unique case (i_kind)
            ROM_TANH: begin
                y0 = tab_tanh[i_idx];
                y1 = tab_tanh[idx1];
            end
            ROM_SIG: begin
                y0 = tab_sig[i_idx];
                y1 = tab_sig[idx1];
            end
            default: begin
                y0 = tab_exp[i_idx];
                y1 = tab_exp[idx1];
            end
        endcase
        n_y0 = y0;
        n_d  = (LUT_W+1)'(y1) - (LUT_W+1)'(y0);
    end

    // stage 2: segment endpoints
    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_y0   <= n_y0;
            r_d    <= n_d;
            r_frac <= i_frac;
        end
    end

    // stage 3: linear interpolation, round to nearest (ties up) via offset and arithmetic shift
    always_comb begin
        prod  = (LUT_W+FRAC_W+3)'(r_d) * $signed({1'b0, r_frac})
              + (LUT_W+FRAC_W+3)'(2048);
        n_lut = r_y0 + LUT_W'(prod >>> FRAC_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_lut <= n_lut;
        end
    end

    assign o_lut = r_lut;

endmodule

// ----- hdl/nau_post.sv -----
`timescale 1ns / 1ps

module nau_post #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                             i_clk,
    input  nau_pkg::t_pipe_ctl               i_ctl,
    input  nau_pkg::t_mode                   i_mode,
    input  logic [nau_pkg::CLIP_W-1:0]       i_clip,
    input  logic signed [nau_pkg::ALPHA_W-1:0] i_alpha,
    input  logic signed [DATA_WIDTH-1:0]     i_x,
    input  logic signed [nau_pkg::LUT_W-1:0] i_lut,
    output logic [DATA_WIDTH-1:0]            o_result
);
    import nau_pkg::*;

    localparam int MW = ((DATA_WIDTH > LUT_W) ? DATA_WIDTH : LUT_W) + 1;
    localparam int VW = MW + ALPHA_W;
    localparam logic signed [VW-1:0] SAT_HI = VW'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

    logic signed [MW-1:0] mul_a;
    logic signed [VW-1:0] n_prod;
    logic signed [VW-1:0] n_alt;
    logic                 n_use_prod;
    logic signed [VW-1:0] r_prod;
    logic signed [VW-1:0] r_alt;
    logic                 r_use_prod;
    logic signed [VW-1:0] xw;
    logic signed [VW-1:0] rounded;
    logic signed [VW-1:0] y;
    logic [DATA_WIDTH-1:0] n_result;
    logic [DATA_WIDTH-1:0] r_result;

    // stage 4: one shared multiplier, plus the non-multiplying results
    always_comb begin
        xw = VW'(i_x);
        if (i_mode == MODE_ELU) begin
            mul_a = MW'(i_lut) - MW'(Q8_ONE);
        end else begin
            mul_a = MW'(i_x);
        end
        n_prod     = VW'(mul_a) * VW'(i_alpha);
        n_use_prod = 1'b0;
        unique case (i_mode)
            MODE_RELU: n_alt = i_x[DATA_WIDTH-1] ? '0 : xw;
            MODE_CLIP: begin
                if (i_x[DATA_WIDTH-1]) begin
                    n_alt = '0;
                end else if (xw > VW'({1'b0, i_clip})) begin
                    n_alt = VW'({1'b0, i_clip});
                end else begin
                    n_alt = xw;
                end
            end
            MODE_LEAKY, MODE_ELU: begin
                n_alt      = xw;
                n_use_prod = i_x[DATA_WIDTH-1];
            end
            MODE_TANH, MODE_SIG: n_alt = VW'(i_lut);
            default:             n_alt = xw;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_prod     <= n_prod;
            r_alt      <= n_alt;
            r_use_prod <= n_use_prod;
        end
    end

    // stage 5: round Q16.16 to Q8.8 (ties up), saturate
    always_comb begin
        rounded = (r_prod + VW'(128)) >>> 8;
        y       = r_use_prod ? rounded : r_alt;
        if (y > SAT_HI) begin
            n_result = SAT_HI[DATA_WIDTH-1:0];
        end else if (y < SAT_LO) begin
            n_result = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            n_result = y[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en5) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
